/* rtl/core/rtab_pkg.sv */
package rtab_pkg;

    // fixed field widths
    localparam int ADDR_W  = 32;
    localparam int FLAG_W  = 16;
    localparam int DEV_W   = 4;
    localparam int HALF_W  = 16;
    localparam int HIT_W   = 4;
    localparam int STAT_W  = 2;

    // route flag bits
    localparam logic [FLAG_W-1:0] FLAG_GATEWAY = 16'h0002;
    localparam logic [FLAG_W-1:0] FLAG_HOST    = 16'h0004;

    localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_MASK = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_NO_ROUTE = 2'd3;

    // one stored route
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [FLAG_W-1:0] flags;
        logic [DEV_W-1:0]  device;
        logic [HALF_W-1:0] mtu;
        logic [ADDR_W-1:0] window;
        logic [HALF_W-1:0] irtt;
        logic [HALF_W-1:0] metric;
    } rtab_entry_t;

    // compare unit result
    typedef struct packed {
        logic hit;
        logic gateway;
    } rtab_match_t;

endpackage

/* rtl/core/rtab_store.sv */
module rtab_store
    import rtab_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  rtab_entry_t       wr_data,
    input  logic [IDX_W-1:0]  rd_addr,
    output rtab_entry_t       rd_data
);

    rtab_entry_t mem [DEPTH];
    rtab_entry_t rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/rtab_match.sv */
module rtab_match
    import rtab_pkg::*;
(
    input  rtab_entry_t        entry,
    input  logic [ADDR_W-1:0]  address,
    output rtab_match_t        result
);

    // masked destination compare, gateway class
    always_comb
    begin
        result.hit     = (((entry.dest ^ address) & entry.mask) == '0);
        result.gateway = ((entry.flags & FLAG_GATEWAY) != '0);
    end

endmodule

/* rtl/core/rtab_mask_check.sv */
module rtab_mask_check
    import rtab_pkg::*;
(
    input  logic [ADDR_W-1:0] mask,
    input  logic [ADDR_W-1:0] address,
    output logic              reject
);

    logic [ADDR_W-1:0] inv;
    logic [ADDR_W-1:0] swapped;
    logic [ADDR_W-1:0] swapped_inc;

    // address bits outside the mask, or inverse not a run of low ones after byte swap
    always_comb
    begin
        inv         = ~mask;
        swapped     = {inv[7:0], inv[15:8], inv[23:16], inv[31:24]};
        swapped_inc = swapped + 32'd1;
        reject      = ((address & inv) != '0) || ((swapped & swapped_inc) != '0);
    end

endmodule

/* rtl/core/ipv4_route_table_top.sv */
// channel   direction  handshake               payload
// command   in         start && !busy          mode, address, netmask, next_hop, route_bits,
//                                              device_index, max_segment, window_size,
//                                              initial_rtt, route_cost
// result    out        done (one-cycle strobe) status, hit_index, out_* route fields
//
// an add needs no scan: done follows the accepting edge
// a lookup scans the stored entries in order and stops at a direct route; the scan reads one stored entry
// per cycle from the single read port of the route memory through one compare unit
// reset clears the entry count and the sequencer; route memory is not cleared
// the receiver cannot stall: each result is shown for exactly one cycle
module ipv4_route_table_top
    import rtab_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [ADDR_W-1:0]  address,
    input  logic [ADDR_W-1:0]  netmask,
    input  logic [ADDR_W-1:0]  next_hop,
    input  logic [FLAG_W-1:0]  route_bits,
    input  logic [DEV_W-1:0]   device_index,
    input  logic [HALF_W-1:0]  max_segment,
    input  logic [ADDR_W-1:0]  window_size,
    input  logic [HALF_W-1:0]  initial_rtt,
    input  logic [HALF_W-1:0]  route_cost,
    output logic               done,
    output logic [STAT_W-1:0]  status,
    output logic [HIT_W-1:0]   hit_index,
    output logic [ADDR_W-1:0]  out_destination,
    output logic [ADDR_W-1:0]  out_mask,
    output logic [ADDR_W-1:0]  out_gateway,
    output logic [FLAG_W-1:0]  out_flags,
    output logic [DEV_W-1:0]   out_device,
    output logic [HALF_W-1:0]  out_mtu,
    output logic [ADDR_W-1:0]  out_window,
    output logic [HALF_W-1:0]  out_irtt,
    output logic [HALF_W-1:0]  out_metric
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_REPORT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]  sel_idx_reg, sel_idx_next;
    logic              have_gw_reg, have_gw_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              done_reg, done_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [HIT_W-1:0]  hit_reg, hit_next;
    rtab_entry_t       res_reg, res_next;

    logic              wr_en;
    rtab_entry_t       wr_data;
    logic [IDX_W-1:0]  rd_addr;
    rtab_entry_t       rd_data;
    rtab_match_t       cmp;
    logic [ADDR_W-1:0] eff_mask;
    logic              mask_reject;
    logic              last_entry;
    logic              gw_match;

    rtab_store #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rtab_match u_match (
        .entry   (rd_data),
        .address (addr_reg),
        .result  (cmp)
    );

    rtab_mask_check u_mask (
        .mask    (eff_mask),
        .address (address),
        .reject  (mask_reject)
    );

    // host routes carry a full mask
    assign eff_mask = ((route_bits & FLAG_HOST) != '0) ? ALL_ONES : netmask;

    // new route as stored
    always_comb
    begin
        wr_data.dest    = address;
        wr_data.mask    = eff_mask;
        wr_data.gateway = next_hop;
        wr_data.flags   = route_bits;
        wr_data.device  = device_index;
        wr_data.mtu     = max_segment;
        wr_data.window  = window_size;
        wr_data.irtt    = initial_rtt;
        wr_data.metric  = (route_cost != '0) ? route_cost - 16'd1 : '0;
    end

    assign last_entry = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
    assign gw_match   = cmp.hit && cmp.gateway;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        sel_idx_next  = sel_idx_reg;
        have_gw_next  = have_gw_reg;
        addr_next     = addr_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        hit_next      = hit_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        rd_addr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!mode)
                    begin
                        // add transaction, done is registered on this edge
                        done_next = 1'b1;
                        res_next  = '0;
                        hit_next  = '0;
                        if (mask_reject)
                        begin
                            status_next = STATUS_BAD_MASK;
                        end
                        else if (count_reg == FULL_COUNT)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = STATUS_OK;
                            hit_next    = HIT_W'(count_reg[IDX_W-1:0]);
                        end
                    end
                    else
                    begin
                        // lookup transaction, entry 0 read on this edge
                        addr_next     = address;
                        scan_idx_next = '0;
                        have_gw_next  = 1'b0;
                        if (count_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_NO_ROUTE;
                            hit_next    = '0;
                            res_next    = '0;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (cmp.hit && !cmp.gateway)
                begin
                    // direct route wins at once
                    sel_idx_next = scan_idx_reg;
                    rd_addr      = scan_idx_reg;
                    state_next   = S_REPORT;
                end
                else
                begin
                    have_gw_next = have_gw_reg || gw_match;
                    sel_idx_next = gw_match ? scan_idx_reg : sel_idx_reg;
                    if (last_entry)
                    begin
                        if (have_gw_next)
                        begin
                            rd_addr    = sel_idx_next;
                            state_next = S_REPORT;
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_NO_ROUTE;
                            hit_next    = '0;
                            res_next    = '0;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                        rd_addr       = scan_idx_next;
                    end
                end
            end

            S_REPORT:
            begin
                done_next   = 1'b1;
                status_next = STATUS_OK;
                hit_next    = HIT_W'(sel_idx_reg);
                res_next    = rd_data;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            have_gw_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            have_gw_reg <= have_gw_next;
            done_reg    <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        sel_idx_reg  <= sel_idx_next;
        addr_reg     <= addr_next;
        status_reg   <= status_next;
        hit_reg      <= hit_next;
        res_reg      <= res_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign hit_index       = hit_reg;
    assign out_destination = res_reg.dest;
    assign out_mask        = res_reg.mask;
    assign out_gateway     = res_reg.gateway;
    assign out_flags       = res_reg.flags;
    assign out_device      = res_reg.device;
    assign out_mtu         = res_reg.mtu;
    assign out_window      = res_reg.window;
    assign out_irtt        = res_reg.irtt;
    assign out_metric      = res_reg.metric;

endmodule

/* rtl/core/rtab_checker.sv */
module rtab_checker
    import rtab_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               mode,
    input logic               done,
    input logic [STAT_W-1:0]  status,
    input logic [HIT_W-1:0]   hit_index,
    input logic [ADDR_W-1:0]  out_destination,
    input logic [ADDR_W-1:0]  out_mask,
    input logic [HALF_W-1:0]  out_metric
);

    // an add transaction reports on the next cycle
    a_add_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !mode |=> done)
        else $error("add transaction did not report in one cycle");

    // a lookup either reports at once or keeps the block busy
    a_lookup_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode |=> busy || done)
        else $error("lookup transaction lost");

    // a result never appears while a lookup is still scanning
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // failed transactions carry zero route fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STATUS_OK) |->
            hit_index == '0 && out_destination == '0 && out_mask == '0 && out_metric == '0)
        else $error("nonzero route fields on failed transaction");

endmodule

bind ipv4_route_table_top rtab_checker u_rtab_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .mode            (mode),
    .done            (done),
    .status          (status),
    .hit_index       (hit_index),
    .out_destination (out_destination),
    .out_mask        (out_mask),
    .out_metric      (out_metric)
);

/* dv/ipv4_route_table_top_tb.sv */
module ipv4_route_table_top_tb
    import rtab_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUTE_SLOTS = 16;
    localparam int RANDOM_ITEMS = 600;

    // command kinds
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] netmask;
        logic [ADDR_W-1:0] next_hop;
        logic [FLAG_W-1:0] route_bits;
        logic [DEV_W-1:0]  device_index;
        logic [HALF_W-1:0] max_segment;
        logic [ADDR_W-1:0] window_size;
        logic [HALF_W-1:0] initial_rtt;
        logic [HALF_W-1:0] route_cost;
    } route_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [HIT_W-1:0]  hit_index;
        rtab_entry_t       route;
    } route_result_t;

    typedef struct {
        route_cmd_t        cmd;
        bit                typed;
        logic [STAT_W-1:0] status;
        logic [HIT_W-1:0]  hit_index;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               mode;
    logic [ADDR_W-1:0]  address;
    logic [ADDR_W-1:0]  netmask;
    logic [ADDR_W-1:0]  next_hop;
    logic [FLAG_W-1:0]  route_bits;
    logic [DEV_W-1:0]   device_index;
    logic [HALF_W-1:0]  max_segment;
    logic [ADDR_W-1:0]  window_size;
    logic [HALF_W-1:0]  initial_rtt;
    logic [HALF_W-1:0]  route_cost;
    logic               done;
    logic [STAT_W-1:0]  status;
    logic [HIT_W-1:0]   hit_index;
    logic [ADDR_W-1:0]  out_destination;
    logic [ADDR_W-1:0]  out_mask;
    logic [ADDR_W-1:0]  out_gateway;
    logic [FLAG_W-1:0]  out_flags;
    logic [DEV_W-1:0]   out_device;
    logic [HALF_W-1:0]  out_mtu;
    logic [ADDR_W-1:0]  out_window;
    logic [HALF_W-1:0]  out_irtt;
    logic [HALF_W-1:0]  out_metric;

    // shadow copy of the route table
    rtab_entry_t   installed_routes [ROUTE_SLOTS];
    int            routes_installed;

    route_result_t pending_results[$];
    directed_row_t directed_rows[$];
    int            mismatch_count;
    int            adds_ok, adds_bad_mask, adds_full;
    int            lookups_found, lookups_missed, results_seen;

    ipv4_route_table_top #(
        .TABLE_DEPTH(ROUTE_SLOTS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .address        (address),
        .netmask        (netmask),
        .next_hop       (next_hop),
        .route_bits     (route_bits),
        .device_index   (device_index),
        .max_segment    (max_segment),
        .window_size    (window_size),
        .initial_rtt    (initial_rtt),
        .route_cost     (route_cost),
        .done           (done),
        .status         (status),
        .hit_index      (hit_index),
        .out_destination(out_destination),
        .out_mask       (out_mask),
        .out_gateway    (out_gateway),
        .out_flags      (out_flags),
        .out_device     (out_device),
        .out_mtu        (out_mtu),
        .out_window     (out_window),
        .out_irtt       (out_irtt),
        .out_metric     (out_metric)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // mask must cover the address and its byte-swapped inverse must be 2^k-1
    function automatic bit mask_is_bad(input logic [ADDR_W-1:0] mask,
                                       input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] inv;
        logic [ADDR_W-1:0] swapped;
        inv = ~mask;
        swapped = {inv[7:0], inv[15:8], inv[23:16], inv[31:24]};
        return ((addr & inv) != '0) || ((swapped & (swapped + 32'd1)) != '0);
    endfunction

    // install a route or resolve a destination against the shadow table
    function automatic route_result_t route_outcome(input route_cmd_t c);
        route_result_t     r;
        logic [ADDR_W-1:0] m;
        int                first_direct;
        int                last_gateway;
        int                pick;
        r = '0;
        if (c.mode == MODE_ADD)
        begin
            m = ((c.route_bits & FLAG_HOST) != '0) ? ALL_ONES : c.netmask;
            if (mask_is_bad(m, c.address))
            begin
                r.status = STATUS_BAD_MASK;
                adds_bad_mask++;
            end
            else if (routes_installed >= ROUTE_SLOTS)
            begin
                r.status = STATUS_FULL;
                adds_full++;
            end
            else
            begin
                installed_routes[routes_installed] = '{
                    dest:    c.address,
                    mask:    m,
                    gateway: c.next_hop,
                    flags:   c.route_bits,
                    device:  c.device_index,
                    mtu:     c.max_segment,
                    window:  c.window_size,
                    irtt:    c.initial_rtt,
                    metric:  (c.route_cost == '0) ? '0 : c.route_cost - 16'd1
                };
                r.status = STATUS_OK;
                r.hit_index = routes_installed[HIT_W-1:0];
                routes_installed++;
                adds_ok++;
            end
        end
        else
        begin
            first_direct = -1;
            last_gateway = -1;
            for (int i = 0; i < routes_installed && first_direct < 0; i++)
            begin
                if (((installed_routes[i].dest ^ c.address) & installed_routes[i].mask) == '0)
                begin
                    if ((installed_routes[i].flags & FLAG_GATEWAY) != '0)
                        last_gateway = i;
                    else
                        first_direct = i;
                end
            end
            pick = (first_direct >= 0) ? first_direct : last_gateway;
            if (pick < 0)
            begin
                r.status = STATUS_NO_ROUTE;
                lookups_missed++;
            end
            else
            begin
                r.status = STATUS_OK;
                r.hit_index = pick[HIT_W-1:0];
                r.route = installed_routes[pick];
                lookups_found++;
            end
        end
        return r;
    endfunction

    function automatic route_cmd_t make_cmd(
        input logic mode_i, input logic [31:0] addr_i, input logic [31:0] mask_i,
        input logic [31:0] hop_i, input logic [15:0] bits_i, input logic [3:0] dev_i,
        input logic [15:0] mss_i, input logic [31:0] win_i, input logic [15:0] rtt_i,
        input logic [15:0] cost_i);
        return '{mode_i, addr_i, mask_i, hop_i, bits_i, dev_i, mss_i, win_i, rtt_i, cost_i};
    endfunction

    task automatic add_row(input route_cmd_t c, input bit typed,
                           input logic [STAT_W-1:0] st, input logic [HIT_W-1:0] hit);
        directed_row_t row;
        row.cmd = c;
        row.typed = typed;
        row.status = st;
        row.hit_index = hit;
        directed_rows.push_back(row);
    endtask

    // mask whose byte-swapped inverse has the k low bits set
    function automatic logic [ADDR_W-1:0] contiguous_mask(input int unsigned k);
        logic [63:0]       low;
        logic [ADDR_W-1:0] inv;
        low = (64'd1 << k) - 64'd1;
        inv = {low[7:0], low[15:8], low[23:16], low[31:24]};
        return ~inv;
    endfunction

    // mostly well-formed routes and targeted lookups, some noise
    function automatic route_cmd_t random_cmd();
        route_cmd_t  c;
        int unsigned add_share;
        int unsigned idx;
        int unsigned k;
        c = make_cmd(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                     16'($urandom), 4'($urandom), 16'($urandom), $urandom,
                     16'($urandom), 16'($urandom));
        add_share = (routes_installed < ROUTE_SLOTS) ? 45 : 12;
        if ($urandom_range(0, 99) < add_share)
        begin
            c.mode = MODE_ADD;
            if ($urandom_range(0, 9) < 7)
            begin
                k = ($urandom_range(0, 3) == 0) ? 8 * $urandom_range(0, 3)
                                                : $urandom_range(0, 32);
                c.netmask = contiguous_mask(k);
                if (routes_installed > 0 && $urandom_range(0, 1) == 1)
                    c.address = installed_routes[$urandom_range(0, routes_installed - 1)].dest;
                c.address &= c.netmask;
                if ($urandom_range(0, 3) != 0)
                    c.route_bits &= ~FLAG_HOST;
            end
        end
        else
        begin
            c.mode = MODE_LOOKUP;
            if (routes_installed > 0 && $urandom_range(0, 9) < 7)
            begin
                idx = $urandom_range(0, routes_installed - 1);
                c.address = installed_routes[idx].dest | ($urandom & ~installed_routes[idx].mask);
            end
        end
        return c;
    endfunction

    // present one transaction and wait until the block is no longer busy
    task automatic send_cmd(input route_cmd_t c, input int unsigned gap, input bit drain_first);
        if (gap > 0 || drain_first)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ((gap > 0) ? gap - 1 : 0) @(negedge clk);
            while (drain_first && pending_results.size() != 0)
                @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        mode         <= c.mode;
        address      <= c.address;
        netmask      <= c.netmask;
        next_hop     <= c.next_hop;
        route_bits   <= c.route_bits;
        device_index <= c.device_index;
        max_segment  <= c.max_segment;
        window_size  <= c.window_size;
        initial_rtt  <= c.initial_rtt;
        route_cost   <= c.route_cost;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        route_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result transaction with no command outstanding");
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(status), 32'(want.status));
                check_field("hit_index", 32'(hit_index), 32'(want.hit_index));
                check_field("out_destination", out_destination, want.route.dest);
                check_field("out_mask", out_mask, want.route.mask);
                check_field("out_gateway", out_gateway, want.route.gateway);
                check_field("out_flags", 32'(out_flags), 32'(want.route.flags));
                check_field("out_device", 32'(out_device), 32'(want.route.device));
                check_field("out_mtu", 32'(out_mtu), 32'(want.route.mtu));
                check_field("out_window", out_window, want.route.window);
                check_field("out_irtt", 32'(out_irtt), 32'(want.route.irtt));
                check_field("out_metric", 32'(out_metric), 32'(want.route.metric));
            end
        end
    end

    // stimulus
    initial
    begin
        route_cmd_t    c;
        route_result_t r;
        route_result_t typed_r;
        bit            burst;
        int unsigned   gap;

        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_ADD;
        address = '0;
        netmask = '0;
        next_hop = '0;
        route_bits = '0;
        device_index = '0;
        max_segment = '0;
        window_size = '0;
        initial_rtt = '0;
        route_cost = '0;
        routes_installed = 0;
        mismatch_count = 0;
        burst = 1'b0;

        // directed table
        // empty table
        add_row(make_cmd(MODE_LOOKUP, 32'h0000_0000, '0, '0, '0, '0, '0, '0, '0, '0),
                1'b1, STATUS_NO_ROUTE, '0);
        // address bits outside the mask
        add_row(make_cmd(MODE_ADD, 32'hFF00_0000, 32'h00FF_FFFF, '0, '0, '0, '0, '0, '0, '0),
                1'b1, STATUS_BAD_MASK, '0);
        // mask not contiguous after byte swap
        add_row(make_cmd(MODE_ADD, 32'h0000_0000, 32'hFFFF_00FF, '0, '0, '0, '0, '0, '0, '0),
                1'b1, STATUS_BAD_MASK, '0);
        // all fields at max, host flag overrides a garbage mask
        add_row(make_cmd(MODE_ADD, ALL_ONES, 32'h1234_5678, ALL_ONES, 16'hFFFF, 4'hF,
                         16'hFFFF, ALL_ONES, 16'hFFFF, 16'hFFFF),
                1'b1, STATUS_OK, 4'd0);
        add_row(make_cmd(MODE_LOOKUP, ALL_ONES, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0, '0);
        // two gateway routes for the same prefix, the last one wins
        add_row(make_cmd(MODE_ADD, 32'h0000_000A, 32'h0000_00FF, 32'h0101_A8C0, FLAG_GATEWAY,
                         4'd1, 16'd1500, 32'd65535, 16'd10, 16'd1),
                1'b1, STATUS_OK, 4'd1);
        add_row(make_cmd(MODE_ADD, 32'h0000_000A, 32'h0000_00FF, 32'h0201_A8C0, 16'h0012,
                         4'd2, 16'd576, 32'd8192, 16'd20, 16'd5), 1'b0, '0, '0);
        add_row(make_cmd(MODE_LOOKUP, 32'h0102_030A, '0, '0, '0, '0, '0, '0, '0, '0),
                1'b0, '0, '0);
        // direct route inside the gateway prefix
        add_row(make_cmd(MODE_ADD, 32'h0000_140A, 32'h0000_FFFF, '0, 16'h0001, 4'd3,
                         16'd9000, 32'd1024, 16'd3, 16'd2), 1'b0, '0, '0);
        add_row(make_cmd(MODE_LOOKUP, 32'h5566_140A, '0, '0, '0, '0, '0, '0, '0, '0),
                1'b0, '0, '0);
        add_row(make_cmd(MODE_LOOKUP, 32'h0000_150A, '0, '0, '0, '0, '0, '0, '0, '0),
                1'b0, '0, '0);
        add_row(make_cmd(MODE_LOOKUP, 32'h0000_000B, '0, '0, '0, '0, '0, '0, '0, '0),
                1'b1, STATUS_NO_ROUTE, '0);
        // default gateway route, all zero fields, cost floored at zero
        add_row(make_cmd(MODE_ADD, '0, '0, '0, FLAG_GATEWAY, '0, '0, '0, '0, '0),
                1'b1, STATUS_OK, 4'd4);
        add_row(make_cmd(MODE_LOOKUP, 32'h0000_000B, '0, '0, '0, '0, '0, '0, '0, '0),
                1'b0, '0, '0);
        // zero mask needs a zero address
        add_row(make_cmd(MODE_ADD, 32'h0000_0001, '0, '0, '0, '0, '0, '0, '0, '0),
                1'b1, STATUS_BAD_MASK, '0);
        // direct full-mask route after the default gateway
        add_row(make_cmd(MODE_ADD, 32'h89AB_CDEF, ALL_ONES, 32'h0A00_0001, '0, 4'd7,
                         16'd1400, 32'd4096, 16'd7, 16'd1), 1'b0, '0, '0);
        add_row(make_cmd(MODE_LOOKUP, 32'h89AB_CDEF, '0, '0, '0, '0, '0, '0, '0, '0),
                1'b0, '0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_cmd(directed_rows[i].cmd, $urandom_range(0, 19), 1'b0);
            r = route_outcome(directed_rows[i].cmd);
            if (directed_rows[i].typed)
            begin
                typed_r = '0;
                typed_r.status = directed_rows[i].status;
                typed_r.hit_index = directed_rows[i].hit_index;
                pending_results.push_back(typed_r);
            end
            else
                pending_results.push_back(r);
        end

        // random traffic, with a full drain after the directed part and mid-run
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ((n % 60) == 0)
                burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, 19);
            c = random_cmd();
            send_cmd(c, gap, (n == 0) || (n == RANDOM_ITEMS / 2));
            pending_results.push_back(route_outcome(c));
        end

        // wait for the tail
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (ROUTE_SLOTS + 4) @(posedge clk);

        $display("covered %0d adds accepted, %0d bad masks, %0d on a full table",
                 adds_ok, adds_bad_mask, adds_full);
        $display("covered %0d lookups found, %0d with no route; %0d results checked",
                 lookups_found, lookups_missed, results_seen);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
